// ===== src/bqs_pkg.sv =====
// Bayer quadrant statistics: shared types, constants and helper functions.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package bqs_pkg;

    localparam int PIX_W   = 8;
    localparam int CFG_W   = 13;
    localparam int SZ_W    = 14;
    localparam int SUM_W   = 30;
    localparam int CNT_W   = 23;
    localparam int DIV_W   = 25;
    localparam int QUOT_W  = 8;
    localparam int STEP_W  = 3;
    localparam int QUAD_W  = 2;
    localparam int IDX_W   = 2;

    localparam logic [SUM_W-1:0] SUM_LIMIT   = {SUM_W{1'b1}};
    localparam logic [CNT_W-1:0] COUNT_LIMIT = {CNT_W{1'b1}};

    localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = 13'd640;
    localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = 13'd480;
    localparam logic [PIX_W-1:0] RST_DARK_TH      = 8'd20;
    localparam logic [PIX_W-1:0] RST_BRIGHT_TH    = 8'd235;

    localparam logic [PIX_W-1:0] MIN_INIT = 8'd255;
    localparam logic [PIX_W-1:0] MAX_INIT = 8'd0;

    localparam logic [IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [IDX_W-1:0] CFG_DARK_TH      = 2'd2;
    localparam logic [IDX_W-1:0] CFG_BRIGHT_TH    = 2'd3;

    localparam logic [QUAD_W-1:0] LAST_QUAD = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV_START,
        S_DIV_WAIT,
        S_OUT
    } t_state;

    typedef struct packed {
        logic update;
        logic clear;
    } t_stats_ctl;

    typedef struct packed {
        logic [PIX_W-1:0] min_value;
        logic [PIX_W-1:0] max_value;
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] dark;
        logic [CNT_W-1:0] bright;
    } t_quad_stats;

    // Clears bit 0 of a size register and clamps it to 2..top.
    function automatic logic [SZ_W-1:0] f_eff_size(input logic [CFG_W-1:0] r,
                                                   input logic [SZ_W-1:0] top);
        logic [SZ_W-1:0] v;
        v = {1'b0, r[CFG_W-1:1], 1'b0};
        if (v < SZ_W'(2)) begin
            v = SZ_W'(2);
        end
        if (v > top) begin
            v = top;
        end
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== src/bqs_stats.sv =====
// Per-quadrant accumulators (min, max, sum, dark and bright counts) and raster position.
// Depends on bqs_pkg.
`default_nettype none

module bqs_stats
    import bqs_pkg::*;
#(
    parameter int COL_W = 12,
    parameter int ROW_W = 12
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_stats_ctl        i_ctl,
    input  wire logic [PIX_W-1:0]  i_pixel,
    input  wire logic [SZ_W-1:0]   i_width,
    input  wire logic [SZ_W-1:0]   i_height,
    input  wire logic [PIX_W-1:0]  i_dark_th,
    input  wire logic [PIX_W-1:0]  i_bright_th,
    input  wire logic [QUAD_W-1:0] i_rd_idx,
    output t_quad_stats            o_rd,
    output logic                   o_frame_end
);

    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    t_quad_stats      r_stats [4];
    logic [QUAD_W-1:0] quad;
    logic             row_end;
    logic [SUM_W:0]   sum_ext;
    t_quad_stats      cur;
    t_quad_stats      upd;

    assign quad        = {r_row[0], r_col[0]};
    assign row_end     = SZ_W'(r_col) >= (i_width - SZ_W'(1));
    assign o_frame_end = row_end && (SZ_W'(r_row) >= (i_height - SZ_W'(1)));
    assign o_rd        = r_stats[i_rd_idx];
    assign cur         = r_stats[quad];
    assign sum_ext     = {1'b0, cur.sum} + (SUM_W + 1)'(i_pixel);

    always_comb begin
        upd = cur;
        if (i_pixel < cur.min_value) begin
            upd.min_value = i_pixel;
        end
        if (i_pixel > cur.max_value) begin
            upd.max_value = i_pixel;
        end
        if (sum_ext > {1'b0, SUM_LIMIT}) begin
            upd.sum = SUM_LIMIT;
        end else begin
            upd.sum = sum_ext[SUM_W-1:0];
        end
        if (i_pixel < i_dark_th) begin
            if (cur.dark < COUNT_LIMIT) begin
                upd.dark = cur.dark + CNT_W'(1);
            end
        end else if (i_pixel > i_bright_th) begin
            if (cur.bright < COUNT_LIMIT) begin
                upd.bright = cur.bright + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            for (int q = 0; q < 4; q++) begin
                r_stats[q] <= '{min_value: MIN_INIT, max_value: MAX_INIT,
                                sum: '0, dark: '0, bright: '0};
            end
        end else if (i_ctl.update) begin
            r_stats[quad] <= upd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_ctl.update) begin
            if (o_frame_end) begin
                r_col <= '0;
                r_row <= '0;
            end else if (row_end) begin
                r_col <= '0;
                r_row <= r_row + ROW_W'(1);
            end else begin
                r_col <= r_col + COL_W'(1);
            end
        end
    end

    a_minmax_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.update && !i_ctl.clear |=>
            r_stats[$past(quad)].min_value <= r_stats[$past(quad)].max_value)
        else $error("quadrant min above max after an update");

    a_clear_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.clear |=> r_stats[0].dark == '0 && r_stats[3].bright == '0
            && r_stats[1].sum == '0 && r_stats[2].min_value == MIN_INIT)
        else $error("statistics not cleared");

    a_pos_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.update && o_frame_end |=> r_col == '0 && r_row == '0)
        else $error("position not cleared at frame end");

endmodule

`default_nettype wire

// ===== src/bqs_div.sv =====
// Shared restoring divider for the quadrant mean, one quotient bit per cycle.
// Quotients above the 8-bit range saturate at 255. Depends on bqs_pkg.
`default_nettype none

module bqs_div
    import bqs_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [SUM_W-1:0]  i_dividend,
    input  wire logic [DIV_W-1:0]  i_divisor,
    output logic                   o_done,
    output logic [QUOT_W-1:0]      o_quotient
);

    localparam int TRIAL_W = DIV_W + QUOT_W;

    logic                r_busy;
    logic                r_done;
    logic [STEP_W-1:0]   r_step;
    logic [SUM_W-1:0]    r_rem;
    logic [DIV_W-1:0]    r_den;
    logic [QUOT_W-1:0]   r_quot;
    logic [TRIAL_W-1:0]  trial;
    logic                fits;
    logic                overflow;

    assign overflow = TRIAL_W'(i_dividend) >= {i_divisor, {QUOT_W{1'b0}}};
    assign trial    = TRIAL_W'(r_den) << r_step;
    assign fits     = TRIAL_W'(r_rem) >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                if (overflow) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                    r_step <= STEP_W'(QUOT_W - 1);
                end
            end else if (r_busy) begin
                r_step <= r_step - STEP_W'(1);
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_dividend;
            r_den  <= i_divisor;
            r_quot <= overflow ? {QUOT_W{1'b1}} : '0;
        end else if (r_busy && fits) begin
            r_rem          <= r_rem - trial[SUM_W-1:0];
            r_quot[r_step] <= 1'b1;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quot;

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_start)
        else $error("divider started while busy");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_done && r_busy))
        else $error("divider done while still busy");

    a_last_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && r_step == '0 && !i_start |=> r_done && !r_busy)
        else $error("divider did not finish after its last step");

endmodule

`default_nettype wire

// ===== src/bayer_quadrant_statistics_top.sv =====
// Bayer quadrant statistics top level: configuration registers, frame-end sequencer.
// Depends on bqs_pkg, bqs_stats and bqs_div.
//
// Channel   Direction  Handshake                      Payload
// pixel     in         i_pixel_valid / o_pixel_ready  i_pixel
// result    out        o_result_valid / i_result_ready quadrant, min, max, mean, counts, last
// cfg       in         i_cfg_valid / o_cfg_ready      i_cfg_index, i_cfg_data
//
// Pixel beats are taken back to back while the block is idle. The last pixel of a frame
// starts four results; each takes one run of the shared divider, which ends early when the
// mean saturates, and each result beat then waits for i_result_ready.
// No pixel is accepted until the fourth result beat has been taken.
// Synchronous active-low reset restores the register defaults and clears all statistics.
`default_nettype none

module bayer_quadrant_statistics_top
    import bqs_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_pixel_valid,
    output logic                   o_pixel_ready,
    input  wire logic [PIX_W-1:0]  i_pixel,
    output logic                   o_result_valid,
    input  wire logic              i_result_ready,
    output logic [QUAD_W-1:0]      o_quadrant,
    output logic [PIX_W-1:0]       o_min_value,
    output logic [PIX_W-1:0]       o_max_value,
    output logic [PIX_W-1:0]       o_mean_value,
    output logic [CNT_W-1:0]       o_dark_count,
    output logic [CNT_W-1:0]       o_bright_count,
    output logic                   o_last_result,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_W-1:0]  i_cfg_data
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam logic [SZ_W-1:0] W_TOP = SZ_W'((MAX_WIDTH / 2) * 2);
    localparam logic [SZ_W-1:0] H_TOP = SZ_W'((MAX_HEIGHT / 2) * 2);

    logic [CFG_W-1:0]  r_frame_width;
    logic [CFG_W-1:0]  r_frame_height;
    logic [PIX_W-1:0]  r_dark_th;
    logic [PIX_W-1:0]  r_bright_th;

    t_state            r_state;
    t_state            n_state;
    logic [QUAD_W-1:0] r_k;
    logic [DIV_W-1:0]  r_divisor;

    logic [QUAD_W-1:0] r_quadrant;
    logic [PIX_W-1:0]  r_min_value;
    logic [PIX_W-1:0]  r_max_value;
    logic [PIX_W-1:0]  r_mean_value;
    logic [CNT_W-1:0]  r_dark_count;
    logic [CNT_W-1:0]  r_bright_count;
    logic              r_last_result;

    logic [SZ_W-1:0]   eff_w;
    logic [SZ_W-1:0]   eff_h;
    logic [2*(SZ_W-1)-1:0] product;
    logic              pixel_acc;
    logic              result_acc;
    logic              frame_end;
    logic              div_start;
    logic              div_done;
    logic [QUOT_W-1:0] quotient;
    t_stats_ctl        stats_ctl;
    t_quad_stats       rd;

    assign eff_w   = f_eff_size(r_frame_width, W_TOP);
    assign eff_h   = f_eff_size(r_frame_height, H_TOP);
    assign product = eff_w[SZ_W-1:1] * eff_h[SZ_W-1:1];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= RST_FRAME_WIDTH;
            r_frame_height <= RST_FRAME_HEIGHT;
            r_dark_th      <= RST_DARK_TH;
            r_bright_th    <= RST_BRIGHT_TH;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                CFG_DARK_TH:      r_dark_th      <= i_cfg_data[PIX_W-1:0];
                CFG_BRIGHT_TH:    r_bright_th    <= i_cfg_data[PIX_W-1:0];
                default:          r_dark_th      <= r_dark_th;
            endcase
        end
    end

    assign pixel_acc  = i_pixel_valid && o_pixel_ready;
    assign result_acc = o_result_valid && i_result_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (pixel_acc && frame_end) begin
                    n_state = S_DIV_START;
                end
            end
            S_DIV_START: begin
                n_state = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_result_ready) begin
                    n_state = (r_k == LAST_QUAD) ? S_IDLE : S_DIV_START;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_pixel_ready    = 1'b0;
        o_result_valid   = 1'b0;
        div_start        = 1'b0;
        stats_ctl.update = 1'b0;
        stats_ctl.clear  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_pixel_ready    = 1'b1;
                stats_ctl.update = i_pixel_valid;
            end
            S_DIV_START: begin
                div_start = 1'b1;
            end
            S_DIV_WAIT: begin
                div_start = 1'b0;
            end
            S_OUT: begin
                o_result_valid  = 1'b1;
                stats_ctl.clear = i_result_ready && (r_k == LAST_QUAD);
            end
            default: begin
                o_pixel_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_IDLE) begin
                r_k <= '0;
            end else if (result_acc) begin
                r_k <= r_k + QUAD_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pixel_acc && frame_end) begin
            r_divisor <= product[DIV_W-1:0];
        end
        if (r_state == S_DIV_WAIT && div_done) begin
            r_quadrant     <= r_k;
            r_min_value    <= rd.min_value;
            r_max_value    <= rd.max_value;
            r_mean_value   <= quotient;
            r_dark_count   <= rd.dark;
            r_bright_count <= rd.bright;
            r_last_result  <= (r_k == LAST_QUAD);
        end
    end

    assign o_quadrant     = r_quadrant;
    assign o_min_value    = r_min_value;
    assign o_max_value    = r_max_value;
    assign o_mean_value   = r_mean_value;
    assign o_dark_count   = r_dark_count;
    assign o_bright_count = r_bright_count;
    assign o_last_result  = r_last_result;

    bqs_stats #(
        .COL_W (COL_W),
        .ROW_W (ROW_W)
    ) u_stats (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (stats_ctl),
        .i_pixel     (i_pixel),
        .i_width     (eff_w),
        .i_height    (eff_h),
        .i_dark_th   (r_dark_th),
        .i_bright_th (r_bright_th),
        .i_rd_idx    (r_k),
        .o_rd        (rd),
        .o_frame_end (frame_end)
    );

    bqs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (rd.sum),
        .i_divisor  (r_divisor),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_pixel_ready && o_result_valid))
        else $error("pixel and result sides active together");

    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (o_last_result == (o_quadrant == LAST_QUAD)))
        else $error("last flag does not match quadrant");

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> o_quadrant == r_k)
        else $error("result quadrant out of order");

    a_back_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        result_acc && o_last_result |=> o_pixel_ready)
        else $error("block not ready after the frame's last result");

endmodule

`default_nettype wire
